### rtl/core/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

    localparam int unsigned STEP_W = 3;

    localparam logic [31:0] SECS_PER_MIN  = 32'd60;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_YEAR     = 32'd31536000;
    localparam logic [31:0] SECS_LEAP     = 32'd31622400;
    localparam logic [11:0] FIRST_YEAR    = 12'd1970;
    localparam logic [3:0]  LAST_MONTH    = 4'd12;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_LOOP,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        U_NONE,
        U_YEAR,
        U_MONTH,
        U_DAY,
        U_HOUR,
        U_MIN
    } t_unit;

    typedef struct packed {
        t_op   op;
        t_unit unit;
        t_step next;
    } t_uword;

    localparam t_step STEP_LOAD  = 3'd0;
    localparam t_step STEP_YEAR  = 3'd1;
    localparam t_step STEP_MONTH = 3'd2;
    localparam t_step STEP_DAY   = 3'd3;
    localparam t_step STEP_HOUR  = 3'd4;
    localparam t_step STEP_MIN   = 3'd5;
    localparam t_step STEP_EMIT  = 3'd6;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        unique case (step)
            STEP_LOAD:  w = '{op: OP_LOAD, unit: U_NONE,  next: STEP_YEAR};
            STEP_YEAR:  w = '{op: OP_LOOP, unit: U_YEAR,  next: STEP_MONTH};
            STEP_MONTH: w = '{op: OP_LOOP, unit: U_MONTH, next: STEP_DAY};
            STEP_DAY:   w = '{op: OP_LOOP, unit: U_DAY,   next: STEP_HOUR};
            STEP_HOUR:  w = '{op: OP_LOOP, unit: U_HOUR,  next: STEP_MIN};
            STEP_MIN:   w = '{op: OP_LOOP, unit: U_MIN,   next: STEP_EMIT};
            STEP_EMIT:  w = '{op: OP_EMIT, unit: U_NONE,  next: STEP_LOAD};
            default:    w = '{op: OP_LOAD, unit: U_NONE,  next: STEP_LOAD};
        endcase
        return w;
    endfunction

    // years in range run 1970 to 2106, so 2100 is the only century to skip
    function automatic logic is_leap(input logic [11:0] year);
        return (year[1:0] == 2'b00) && (year != 12'd2100);
    endfunction

    function automatic logic [31:0] month_secs(input logic [3:0] month, input logic leap);
        logic [31:0] s;
        case (month)
            4'd2:                      s = leap ? 32'd2505600 : 32'd2419200;
            4'd4, 4'd6, 4'd9, 4'd11:   s = 32'd2592000;
            default:                   s = 32'd2678400;
        endcase
        return s;
    endfunction

endpackage

### rtl/core/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps

// channel  | direction | handshake                  | payload
// in       | input     | i_in_valid / o_in_ready    | i_epoch_seconds
// out      | output    | o_out_valid / i_out_ready  | o_year o_month o_day o_hour o_minute o_second
//
// a word is loaded, whole years, months, days, hours and minutes are counted off in turn
// by one shared 32-bit subtract and compare, and the result is then emitted
// the next word is taken while a finished result waits in the output register
// a result stalled at the output holds the sequencer at its final step
// synchronous active-low reset returns the step counter to load and drops o_out_valid

module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);
    import esc_pkg::*;

    t_step       r_step, n_step;
    t_uword      uw;
    logic [31:0] r_rem, n_rem;
    logic [11:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic        r_out_valid, n_out_valid;
    logic [31:0] opnd;
    logic [32:0] diff;
    logic        take;
    logic        out_load;

    assign uw = ucode(r_step);

    always_comb begin
        unique case (uw.unit)
            U_YEAR:  opnd = is_leap(r_year) ? SECS_LEAP : SECS_YEAR;
            U_MONTH: opnd = month_secs(r_month, is_leap(r_year));
            U_DAY:   opnd = SECS_PER_DAY;
            U_HOUR:  opnd = SECS_PER_HOUR;
            U_MIN:   opnd = SECS_PER_MIN;
            default: opnd = SECS_PER_MIN;
        endcase
    end

    assign diff = {1'b0, r_rem} - {1'b0, opnd};
    assign take = (uw.op == OP_LOOP) && !diff[32]
                  && !((uw.unit == U_MONTH) && (r_month == LAST_MONTH));
    assign o_in_ready = (uw.op == OP_LOAD);
    assign out_load = (uw.op == OP_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_step      = r_step;
        n_rem       = r_rem;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_hour      = r_hour;
        n_min       = r_min;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (uw.op)
            OP_LOAD: begin
                if (i_in_valid) begin
                    n_rem   = i_epoch_seconds;
                    n_year  = FIRST_YEAR;
                    n_month = 4'd1;
                    n_day   = 5'd1;
                    n_hour  = 5'd0;
                    n_min   = 6'd0;
                    n_step  = uw.next;
                end
            end
            OP_LOOP: begin
                if (take) begin
                    n_rem = diff[31:0];
                    case (uw.unit)
                        U_YEAR:  n_year  = r_year + 12'd1;
                        U_MONTH: n_month = r_month + 4'd1;
                        U_DAY:   n_day   = r_day + 5'd1;
                        U_HOUR:  n_hour  = r_hour + 5'd1;
                        U_MIN:   n_min   = r_min + 6'd1;
                        default: n_rem   = r_rem;
                    endcase
                end else begin
                    n_step = uw.next;
                end
            end
            OP_EMIT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_step      = uw.next;
                end
            end
            default: n_step = STEP_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_rem   <= n_rem;
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_hour  <= n_hour;
        r_min   <= n_min;
        if (out_load) begin
            o_year   <= r_year;
            o_month  <= r_month;
            o_day    <= r_day;
            o_hour   <= r_hour;
            o_minute <= r_min;
            o_second <= r_rem[5:0];
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_starts_year : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_step == STEP_YEAR) && (r_year == FIRST_YEAR))
        else $error("accepted word did not start the year loop");

    a_rem_shrinks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == OP_LOOP) |=> (r_rem <= $past(r_rem)))
        else $error("remainder grew during a loop step");

    a_day_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_HOUR) |-> (r_rem < SECS_PER_DAY))
        else $error("hour loop entered with a full day left");

    a_emit_sets_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid && (o_second == $past(r_rem[5:0])))
        else $error("result load did not raise o_out_valid");

    a_month_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == OP_LOOP) |-> (r_month >= 4'd1) && (r_month <= LAST_MONTH))
        else $error("month counter out of range");

endmodule
